// ----- src/slid_pkg.sv -----
// Shared types and constants for the sorted list core.
// Used by the list cell and by the top level; depends on nothing else.
package slid_pkg;

   localparam int CAPACITY = 16;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Request operation codes.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // Response status codes.
   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_ENTRY     = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   // Command broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] head;
   } cell_cmd_type;

   // Occupancy of one cell, derived from the entry count.
   typedef struct packed {
      logic valid;
      logic tail;
   } cell_flags_type;

   // Comparison results that a cell reports.
   typedef struct packed {
      logic lt;
      logic eq;
   } cell_cmp_type;

endpackage

// ----- src/slid_cell.sv -----
// One cell of the sorted chain: holds a single entry and compares it with
// the broadcast value. Depends on slid_pkg.
module slid_cell (
   input  logic                                clock,
   input  slid_pkg::cell_cmd_type              cmd,
   input  slid_pkg::cell_flags_type            flags,
   input  logic signed [slid_pkg::VALUE_W-1:0] left_entry,
   input  logic                                left_lt,
   input  logic signed [slid_pkg::VALUE_W-1:0] right_entry,
   output logic signed [slid_pkg::VALUE_W-1:0] entry,
   output slid_pkg::cell_cmp_type              cmp
);

   logic signed [slid_pkg::VALUE_W-1:0] entry_ff;
   logic signed [slid_pkg::VALUE_W-1:0] entry_in;
   logic                                below;

   // The broadcast value sorts before this entry.
   assign below   = cmd.value < entry_ff;
   assign cmp.lt  = flags.valid && below;
   assign cmp.eq  = flags.valid && (cmd.value == entry_ff);
   assign entry   = entry_ff;

   // Next entry: shift right on insert, shift left on delete, rotate on read.
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         slid_pkg::CMD_INSERT: begin
            if (left_lt) begin
               entry_in = left_entry;
            end else if (cmp.lt || !flags.valid) begin
               entry_in = cmd.value;
            end
         end
         slid_pkg::CMD_DELETE: begin
            // Entries at or above the deleted value close the gap.
            if (flags.valid && (below || cmp.eq)) begin
               entry_in = right_entry;
            end
         end
         slid_pkg::CMD_ROTATE: begin
            if (flags.tail) begin
               entry_in = cmd.head;
            end else if (flags.valid) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Entry storage has no reset; only occupied cells are ever read.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- src/sorted_list_insert_delete_core.sv -----
// Top level of the sorted list core: chain of list cells plus control.
// Depends on slid_pkg and slid_cell.
//
//   channel | direction | ports                                         | handshake
//   req     | in        | req_operation, req_value                      | req_valid / req_stall
//   rsp     | out       | rsp_entry_value, rsp_status, rsp_last         | rsp_valid / rsp_stall
//
// Insert, delete and unused codes give at most one transaction each, so one
// such request is accepted per cycle while the output register drains. A read
// of N entries is accepted, then N steps each rotate the occupied cells once
// and give one response; an empty read gives one response.
// Reset clears the entry count and the control state only.
// A stalled response holds the output register and the chain stops with it.
module sorted_list_insert_delete_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic signed [slid_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [slid_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   localparam int CAP = slid_pkg::CAPACITY;
   localparam int CW  = slid_pkg::COUNT_W;

   state_type                           state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       remain_ff, remain_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [slid_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [2:0]                          rsp_status_ff, rsp_status_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                can_load;
   logic                                accept;
   logic                                full;
   logic                                found;
   slid_pkg::cell_cmd_type              cmd;
   slid_pkg::cell_flags_type            flags_w [CAP];
   slid_pkg::cell_cmp_type              cmp_w   [CAP];
   logic signed [slid_pkg::VALUE_W-1:0] entry_w [CAP];
   logic [CAP-1:0]                      valid_w;
   logic [CAP-1:0]                      eq_w;

   // Handshake: the output register may load when empty or being taken.
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !can_load;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CW'(CAP);
   assign found     = |eq_w;

   // Cell occupancy from the entry count.
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         valid_w[i] = CW'(i) < count_ff;
         eq_w[i]    = cmp_w[i].eq;
      end
      for (int i = 0; i < CAP; i++) begin
         flags_w[i].valid = valid_w[i];
         if (i == CAP - 1) begin
            flags_w[i].tail = valid_w[i];
         end else begin
            flags_w[i].tail = valid_w[i] && !valid_w[(i + 1) % CAP];
         end
      end
   end

   // Command broadcast to the chain.
   always_comb begin
      cmd.value = req_value;
      cmd.head  = entry_w[0];
      cmd.op    = slid_pkg::CMD_HOLD;
      if (state_ff == S_READ) begin
         if (can_load) begin
            cmd.op = slid_pkg::CMD_ROTATE;
         end
      end else if (accept) begin
         if (req_operation == slid_pkg::OP_INSERT && !full) begin
            cmd.op = slid_pkg::CMD_INSERT;
         end else if (req_operation == slid_pkg::OP_DELETE && found) begin
            cmd.op = slid_pkg::CMD_DELETE;
         end
      end
   end

   // Chain of cells; each cell sees its left and right neighbour where it has one.
   for (genvar g = 0; g < CAP; g++) begin : g_cell
      logic signed [slid_pkg::VALUE_W-1:0] left_entry;
      logic                                left_lt;
      logic signed [slid_pkg::VALUE_W-1:0] right_entry;

      if (g == 0) begin : g_first
         assign left_entry = '0;
         assign left_lt    = 1'b0;
      end else begin : g_inner
         assign left_entry = entry_w[g-1];
         assign left_lt    = cmp_w[g-1].lt;
      end

      if (g == CAP - 1) begin : g_last
         assign right_entry = entry_w[g];
      end else begin : g_mid
         assign right_entry = entry_w[g+1];
      end

      slid_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .flags       (flags_w[g]),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .entry       (entry_w[g]),
         .cmp         (cmp_w[g])
      );
   end

   // Next state, entry count and response register.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = can_load ? 1'b0 : rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in = req_value;
               rsp_last_in  = 1'b1;
               unique case (req_operation)
                  slid_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = slid_pkg::ST_FULL;
                     end else begin
                        rsp_status_in = slid_pkg::ST_DONE;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  slid_pkg::OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_status_in = slid_pkg::ST_DONE;
                        count_in      = count_ff - CW'(1);
                     end else begin
                        rsp_status_in = slid_pkg::ST_NOT_FOUND;
                     end
                  end
                  slid_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = slid_pkg::ST_EMPTY;
                     end else begin
                        state_in  = S_READ;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                     rsp_value_in = rsp_value_ff;
                     rsp_last_in  = rsp_last_ff;
                  end
               endcase
            end
         end
         S_READ: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = entry_w[0];
               rsp_status_in = slid_pkg::ST_ENTRY;
               rsp_last_in   = remain_ff == CW'(1);
               remain_in     = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
